@@ hw/rtl/g2fb_pkg.sv @@
// ----------------------------------------------------------------------------
// g2fb_pkg: shared definitions for the glyph to framebuffer writer
// Holds the glyph size, the pixel format codes, the register indexes and
// small helpers that map a pixel format to its data mask and byte enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package g2fb_pkg;

  // Glyph edge length in pixels, and the counter width for rows and columns.
  localparam int unsigned GLYPH_SIZE = 8;
  localparam int unsigned GW         = (GLYPH_SIZE > 1) ? $clog2(GLYPH_SIZE) : 1;

  // Fixed field widths.
  localparam int unsigned POS_W   = 12;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned BE_W    = 4;
  localparam int unsigned GLYPH_W = 64;
  localparam int unsigned CIDX_W  = 2;

  // Row and column sums carry one extra bit.
  localparam int unsigned YSUM_W = POS_W + 1;
  localparam int unsigned XSUM_W = POS_W + 1;
  localparam int unsigned XOFF_W = XSUM_W + 2;

  // Pixel format codes.
  typedef enum logic [1:0] {
    FMT_8  = 2'd0,
    FMT_16 = 2'd1,
    FMT_24 = 2'd2,
    FMT_32 = 2'd3
  } pix_fmt_e;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_FRAME_BASE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LINE_PITCH   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

  // Byte enables per format.
  localparam logic [BE_W-1:0] BE_8  = 4'h1;
  localparam logic [BE_W-1:0] BE_16 = 4'h3;
  localparam logic [BE_W-1:0] BE_24 = 4'h7;
  localparam logic [BE_W-1:0] BE_32 = 4'hF;

  // Data masks per format.
  localparam logic [DATA_W-1:0] MASK_8  = 32'h0000_00FF;
  localparam logic [DATA_W-1:0] MASK_16 = 32'h0000_FFFF;
  localparam logic [DATA_W-1:0] MASK_24 = 32'h00FF_FFFF;
  localparam logic [DATA_W-1:0] MASK_32 = 32'hFFFF_FFFF;

  // Data mask for a pixel format.
  function automatic logic [DATA_W-1:0] fmt_mask(input pix_fmt_e fmt);
    logic [DATA_W-1:0] m;
    unique case (fmt)
      FMT_8:   m = MASK_8;
      FMT_16:  m = MASK_16;
      FMT_24:  m = MASK_24;
      default: m = MASK_32;
    endcase
    return m;
  endfunction

  // Byte enable for a pixel format.
  function automatic logic [BE_W-1:0] fmt_enable(input pix_fmt_e fmt);
    logic [BE_W-1:0] be;
    unique case (fmt)
      FMT_8:   be = BE_8;
      FMT_16:  be = BE_16;
      FMT_24:  be = BE_24;
      default: be = BE_32;
    endcase
    return be;
  endfunction

endpackage

@@ hw/rtl/glyph_to_framebuffer_writer_top.sv @@
// ----------------------------------------------------------------------------
// glyph_to_framebuffer_writer_top: 8x8 glyph blitter to framebuffer writes
// An item's first write passes the pixel counters, offset stage and output registers.
// Throughput: one write per cycle while an item is active, one write per glyph pixel;
// items follow back to back.
// The receiver cannot stall; each write is shown for one cycle with write_strobe_o.
// Reset clears control state and sets frame_base 0, line_pitch 0, format 32 bpp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_to_framebuffer_writer_top
  import g2fb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Item command channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [POS_W-1:0]     pos_x_i,
  input  logic [POS_W-1:0]     pos_y_i,
  input  logic [GLYPH_W-1:0]   glyph_rows_i,
  input  logic [DATA_W-1:0]    fore_color_i,
  input  logic [DATA_W-1:0]    back_color_i,

  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CIDX_W-1:0]    cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,

  // Framebuffer write results
  output logic                 write_strobe_o,
  output logic [ADDR_W-1:0]    write_address_o,
  output logic [DATA_W-1:0]    write_data_o,
  output logic [BE_W-1:0]      byte_enable_o,
  output logic                 last_write_o
);

  localparam logic [GW-1:0] LAST_IDX = GW'(GLYPH_SIZE - 1);

  // Configuration registers
  logic [ADDR_W-1:0]  frame_base_q;
  logic [PITCH_W-1:0] line_pitch_q;
  pix_fmt_e           pixel_format_q;

  // Item registers and pixel counters
  logic               act_q;
  logic [GW-1:0]      col_q, row_q;
  logic [POS_W-1:0]   pos_x_q, pos_y_q;
  logic [GLYPH_W-1:0] glyph_q;
  logic [DATA_W-1:0]  fore_q, back_q;

  // Offset stage
  logic               vld_b_q, last_b_q;
  logic [ADDR_W-1:0]  row_off_q;
  logic [XOFF_W-1:0]  col_off_q;
  logic [DATA_W-1:0]  data_b_q;

  // Output registers
  logic               strobe_q, last_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [DATA_W-1:0]  data_q;
  logic [BE_W-1:0]    be_q;

  logic               accept;
  logic               last_a;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q   <= '0;
      line_pitch_q   <= '0;
      pixel_format_q <= FMT_32;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FRAME_BASE:   frame_base_q   <= cfg_data_i;
        REG_LINE_PITCH:   line_pitch_q   <= cfg_data_i[PITCH_W-1:0];
        REG_PIXEL_FORMAT: pixel_format_q <= pix_fmt_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // A new item is taken while the last pixel of the current one is issued.
  assign last_a  = act_q && (col_q == LAST_IDX) && (row_q == LAST_IDX);
  assign busy_o  = act_q && !last_a;
  assign accept  = start_i && !busy_o;

  // Pixel counters: columns outer, rows inner.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      act_q <= 1'b1;
      col_q <= '0;
      row_q <= '0;
    end else if (act_q) begin
      if (last_a) begin
        act_q <= 1'b0;
      end
      if (row_q == LAST_IDX) begin
        row_q <= '0;
        col_q <= col_q + GW'(1);
      end else begin
        row_q <= row_q + GW'(1);
      end
    end
  end

  // Item payload capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      glyph_q <= glyph_rows_i;
      fore_q  <= fore_color_i;
      back_q  <= back_color_i;
    end
  end

  // Pixel bit, color and the two address offsets for the current pixel.
  logic [7:0]          row_byte;
  logic                pix_set;
  logic [YSUM_W-1:0]   ysum;
  logic [XSUM_W-1:0]   xsum;
  logic [XOFF_W-1:0]   xoff;
  logic [ADDR_W-1:0]   yoff;

  always_comb begin
    row_byte = glyph_q[{3'(row_q), 3'b000} +: 8];
    pix_set  = row_byte[3'(col_q)];
    ysum     = YSUM_W'(pos_y_q) + YSUM_W'(row_q);
    xsum     = XSUM_W'(pos_x_q) + XSUM_W'(col_q);
    yoff     = ADDR_W'(line_pitch_q) * ADDR_W'(ysum);
    unique case (pixel_format_q)
      FMT_8:   xoff = XOFF_W'(xsum);
      FMT_16:  xoff = XOFF_W'({xsum, 1'b0});
      FMT_24:  xoff = XOFF_W'(xsum) + XOFF_W'({xsum, 1'b0});
      default: xoff = XOFF_W'({xsum, 2'b00});
    endcase
  end

  // Offset stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q  <= 1'b0;
      last_b_q <= 1'b0;
    end else begin
      vld_b_q  <= act_q;
      last_b_q <= last_a;
    end
  end

  always_ff @(posedge clk_i) begin
    row_off_q <= yoff;
    col_off_q <= xoff;
    data_b_q  <= (pix_set ? fore_q : back_q) & fmt_mask(pixel_format_q);
  end

  // Final address sum and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= vld_b_q;
      last_q   <= last_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= frame_base_q + row_off_q + ADDR_W'(col_off_q);
    data_q <= data_b_q;
    be_q   <= fmt_enable(pixel_format_q);
  end

  assign write_strobe_o  = strobe_q;
  assign write_address_o = addr_q;
  assign write_data_o    = data_q;
  assign byte_enable_o   = be_q;
  assign last_write_o    = last_q;

  // Checks on the pixel sequencing.
  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_write_o |-> write_strobe_o)
    else $error("last write flagged without a write strobe");

  a_accept_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (act_q && (col_q == '0) && (row_q == '0)))
    else $error("item taken but pixel counters did not restart");

  a_pixel_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> ##2 write_strobe_o)
    else $error("active pixel did not produce a write two cycles later");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_a && !start_i) |=> !act_q)
    else $error("sequencer still active after the final pixel");

endmodule
